FILE: rtl/modular_inverse_defines.svh
// assertion macros used by the modular inverse top level
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define MI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define MI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mi_pkg.sv
// types, control codes and microcode rom of the modular inverse block
package mi_pkg;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // datapath operations
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE   = 3'd0;
    localparam op_t OP_HALF_U = 3'd1;
    localparam op_t OP_HALF_V = 3'd2;
    localparam op_t OP_SUB    = 3'd3;
    localparam op_t OP_ADD_M  = 3'd4;
    localparam op_t OP_SUB_M  = 3'd5;

    // jump conditions
    typedef logic [3:0] cond_t;
    localparam cond_t COND_NEVER     = 4'd0;
    localparam cond_t COND_M_ZERO    = 4'd1;
    localparam cond_t COND_M_ONE     = 4'd2;
    localparam cond_t COND_A_ZERO    = 4'd3;
    localparam cond_t COND_BOTH_EVEN = 4'd4;
    localparam cond_t COND_U_ODD     = 4'd5;
    localparam cond_t COND_V_ODD     = 4'd6;
    localparam cond_t COND_U_NONZERO = 4'd7;
    localparam cond_t COND_V_NOT_ONE = 4'd8;
    localparam cond_t COND_D_NONNEG  = 4'd9;
    localparam cond_t COND_D_LT_M    = 4'd10;

    // finish codes
    typedef logic [1:0] fin_t;
    localparam fin_t FIN_NONE = 2'd0;
    localparam fin_t FIN_INV  = 2'd1;
    localparam fin_t FIN_FLAG = 2'd2;
    localparam fin_t FIN_ZERO = 2'd3;

    // program addresses
    localparam pc_t PC_CHK_M0  = 4'd0;
    localparam pc_t PC_CHK_M1  = 4'd1;
    localparam pc_t PC_CHK_A0  = 4'd2;
    localparam pc_t PC_CHK_EV  = 4'd3;
    localparam pc_t PC_HALF_U  = 4'd4;
    localparam pc_t PC_HALF_V  = 4'd5;
    localparam pc_t PC_SUB     = 4'd6;
    localparam pc_t PC_LOOP    = 4'd7;
    localparam pc_t PC_GCD     = 4'd8;
    localparam pc_t PC_NORM_LO = 4'd9;
    localparam pc_t PC_NORM_HI = 4'd10;
    localparam pc_t PC_DONE    = 4'd11;
    localparam pc_t PC_FLAG    = 4'd12;
    localparam pc_t PC_ZERO    = 4'd13;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
        logic  stay;
        fin_t  fin;
    } ucode_t;

    typedef struct packed {
        logic m_zero;
        logic m_one;
        logic a_zero;
        logic both_even;
        logic u_odd;
        logic v_odd;
        logic u_nonzero;
        logic v_not_one;
        logic d_nonneg;
        logic d_lt_m;
    } flags_t;

    typedef struct packed {
        logic busy;
        fin_t fin;
    } seq_stat_t;

    // a taken jump skips the op; otherwise the op runs and pc advances unless stay
    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t w;
        unique case (pc)
            PC_CHK_M0:  w = '{OP_NONE,   COND_M_ZERO,    PC_FLAG,    1'b0, FIN_NONE};
            PC_CHK_M1:  w = '{OP_NONE,   COND_M_ONE,     PC_ZERO,    1'b0, FIN_NONE};
            PC_CHK_A0:  w = '{OP_NONE,   COND_A_ZERO,    PC_FLAG,    1'b0, FIN_NONE};
            PC_CHK_EV:  w = '{OP_NONE,   COND_BOTH_EVEN, PC_FLAG,    1'b0, FIN_NONE};
            PC_HALF_U:  w = '{OP_HALF_U, COND_U_ODD,     PC_HALF_V,  1'b1, FIN_NONE};
            PC_HALF_V:  w = '{OP_HALF_V, COND_V_ODD,     PC_SUB,     1'b1, FIN_NONE};
            PC_SUB:     w = '{OP_SUB,    COND_NEVER,     PC_SUB,     1'b0, FIN_NONE};
            PC_LOOP:    w = '{OP_NONE,   COND_U_NONZERO, PC_HALF_U,  1'b0, FIN_NONE};
            PC_GCD:     w = '{OP_NONE,   COND_V_NOT_ONE, PC_FLAG,    1'b0, FIN_NONE};
            PC_NORM_LO: w = '{OP_ADD_M,  COND_D_NONNEG,  PC_NORM_HI, 1'b1, FIN_NONE};
            PC_NORM_HI: w = '{OP_SUB_M,  COND_D_LT_M,    PC_DONE,    1'b1, FIN_NONE};
            PC_DONE:    w = '{OP_NONE,   COND_NEVER,     PC_DONE,    1'b0, FIN_INV};
            PC_FLAG:    w = '{OP_NONE,   COND_NEVER,     PC_FLAG,    1'b0, FIN_FLAG};
            PC_ZERO:    w = '{OP_NONE,   COND_NEVER,     PC_ZERO,    1'b0, FIN_ZERO};
            default:    w = '{OP_NONE,   COND_NEVER,     PC_FLAG,    1'b0, FIN_FLAG};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/mi_ifs.sv
// valid/ready channel interfaces of the modular inverse block
interface mi_req_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface mi_rsp_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] inverse;
    logic         no_inverse;
    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

FILE: rtl/modular_inverse.sv
// top level of the modular inverse block
`include "modular_inverse_defines.svh"

// Modular inverse by the binary extended Euclidean algorithm. Each item on
// req carries a value; the block returns one item on rsp with the inverse of
// that value modulo the modulus register, in 0 .. modulus-1, or no_inverse
// set and inverse 0 when gcd(value, modulus) is not 1 (value 0 unless the
// modulus is 1, and modulus 0 always, give no_inverse; modulus 1 gives
// inverse 0 for every value). Values at or above the modulus are handled
// directly, as their residue.
// One item is worked on at a time. A small microcode program in a rom steps
// a shared datapath through halving of the even operands, one subtract of
// the smaller operand from the larger, then a final fold of the coefficient
// into range; the halving and subtract loop of the sequencer sets the length
// of a run. A new item is taken the cycle after the previous one is
// finished, while its result can still sit in the output register waiting
// for rsp.ready. The modulus is written through cfg_we / cfg_wdata; the user
// must write it only while the block is idle, which the block itself does
// not enforce. It resets to 2.
module modular_inverse
    import mi_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [VALUE_WIDTH-1:0] cfg_wdata,
    mi_req_if.sink                 req,
    mi_rsp_if.source               rsp
);

    localparam int W = VALUE_WIDTH;

    logic [W-1:0] modulus_reg;
    logic         rsp_valid_reg, rsp_valid_next;
    logic [W-1:0] inverse_reg, inverse_next;
    logic         no_inv_reg, no_inv_next;

    logic         in_fire;
    logic         out_free;
    op_t          dp_op;
    seq_stat_t    stat;
    flags_t       flags;
    logic [W-1:0] d_low;

    // take an item only while the sequencer is free
    assign req.ready = !stat.busy;
    assign in_fire   = req.valid && req.ready;

    // the output register can take a result when empty or being drained
    assign out_free = !rsp_valid_reg || rsp.ready;

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= W'(2);
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    mi_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .out_free (out_free),
        .flags    (flags),
        .dp_op    (dp_op),
        .stat     (stat)
    );

    mi_dp #(
        .W (W)
    ) u_dp (
        .clk     (clk),
        .start   (in_fire),
        .value   (req.value),
        .modulus (modulus_reg),
        .op      (dp_op),
        .flags   (flags),
        .d_low   (d_low)
    );

    // result register, loaded by the finishing microcode step
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        inverse_next   = inverse_reg;
        no_inv_next    = no_inv_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (stat.fin)
            FIN_NONE:
            begin
            end
            FIN_INV:
            begin
                rsp_valid_next = 1'b1;
                inverse_next   = d_low;
                no_inv_next    = 1'b0;
            end
            FIN_FLAG:
            begin
                rsp_valid_next = 1'b1;
                inverse_next   = '0;
                no_inv_next    = 1'b1;
            end
            FIN_ZERO:
            begin
                rsp_valid_next = 1'b1;
                inverse_next   = '0;
                no_inv_next    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inverse_reg <= inverse_next;
        no_inv_reg  <= no_inv_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.inverse    = inverse_reg;
    assign rsp.no_inverse = no_inv_reg;

    // an accepted item always starts the sequencer
    `MI_ASSERT_NXT(a_start_busy, in_fire, stat.busy, "item accepted but sequencer idle")

    // a finishing step always leaves a result in the output register
    `MI_ASSERT_NXT(a_fin_loads, stat.fin != FIN_NONE, rsp_valid_reg, "result lost at finish")

    // a missing inverse is always reported as zero
    `MI_ASSERT_IMP(a_flag_zero, rsp_valid_reg && no_inv_reg, inverse_reg == '0,
        "no_inverse set with nonzero inverse")

endmodule

FILE: rtl/mi_seq.sv
// microcode sequencer: step counter, rom and conditional jumps
module mi_seq
    import mi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      out_free,
    input  flags_t    flags,
    output op_t       dp_op,
    output seq_stat_t stat
);

    logic   busy_reg, busy_next;
    pc_t    pc_reg, pc_next;
    ucode_t word;
    logic   cond_hit;
    fin_t   fin;

    always_comb
    begin
        word = ucode_rom(pc_reg);
        unique case (word.cond)
            COND_NEVER:     cond_hit = 1'b0;
            COND_M_ZERO:    cond_hit = flags.m_zero;
            COND_M_ONE:     cond_hit = flags.m_one;
            COND_A_ZERO:    cond_hit = flags.a_zero;
            COND_BOTH_EVEN: cond_hit = flags.both_even;
            COND_U_ODD:     cond_hit = flags.u_odd;
            COND_V_ODD:     cond_hit = flags.v_odd;
            COND_U_NONZERO: cond_hit = flags.u_nonzero;
            COND_V_NOT_ONE: cond_hit = flags.v_not_one;
            COND_D_NONNEG:  cond_hit = flags.d_nonneg;
            COND_D_LT_M:    cond_hit = flags.d_lt_m;
            default:        cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        dp_op     = OP_NONE;
        fin       = FIN_NONE;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = PC_CHK_M0;
        end
        else if (busy_reg)
        begin
            if (word.fin != FIN_NONE)
            begin
                // wait here until the output register can take the result
                if (out_free)
                begin
                    fin       = word.fin;
                    busy_next = 1'b0;
                end
            end
            else if (cond_hit)
            begin
                pc_next = word.target;
            end
            else
            begin
                dp_op = word.op;
                if (!word.stay)
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_CHK_M0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.fin  = fin;

endmodule

FILE: rtl/mi_dp.sv
// binary extended gcd datapath: operands, bezout coefficients, flags
module mi_dp
    import mi_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic         clk,
    input  logic         start,
    input  logic [W-1:0] value,
    input  logic [W-1:0] modulus,
    input  op_t          op,
    output flags_t       flags,
    output logic [W-1:0] d_low
);

    // coefficients stay within a few multiples of the operands
    localparam int CW = W + 4;

    logic [W-1:0]         a_reg, u_reg, v_reg;
    logic [W-1:0]         u_next, v_next;
    logic signed [CW-1:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic signed [CW-1:0] ca_next, cb_next, cc_next, cd_next;
    logic signed [CW-1:0] m_s, y_s;
    logic signed [CW-1:0] ay, bx, cy, dx;
    logic                 u_ge_v;

    assign m_s    = signed'({{(CW-W){1'b0}}, modulus});
    assign y_s    = signed'({{(CW-W){1'b0}}, a_reg});
    assign ay     = ca_reg + y_s;
    assign bx     = cb_reg - m_s;
    assign cy     = cc_reg + y_s;
    assign dx     = cd_reg - m_s;
    assign u_ge_v = u_reg >= v_reg;

    always_comb
    begin
        u_next  = u_reg;
        v_next  = v_reg;
        ca_next = ca_reg;
        cb_next = cb_reg;
        cc_next = cc_reg;
        cd_next = cd_reg;
        unique case (op)
            OP_NONE:
            begin
            end
            OP_HALF_U:
            begin
                u_next = u_reg >> 1;
                if (!ca_reg[0] && !cb_reg[0])
                begin
                    ca_next = ca_reg >>> 1;
                    cb_next = cb_reg >>> 1;
                end
                else
                begin
                    ca_next = ay >>> 1;
                    cb_next = bx >>> 1;
                end
            end
            OP_HALF_V:
            begin
                v_next = v_reg >> 1;
                if (!cc_reg[0] && !cd_reg[0])
                begin
                    cc_next = cc_reg >>> 1;
                    cd_next = cd_reg >>> 1;
                end
                else
                begin
                    cc_next = cy >>> 1;
                    cd_next = dx >>> 1;
                end
            end
            OP_SUB:
            begin
                // subtract the smaller operand from the larger one
                if (u_ge_v)
                begin
                    u_next  = u_reg - v_reg;
                    ca_next = ca_reg - cc_reg;
                    cb_next = cb_reg - cd_reg;
                end
                else
                begin
                    v_next  = v_reg - u_reg;
                    cc_next = cc_reg - ca_reg;
                    cd_next = cd_reg - cb_reg;
                end
            end
            OP_ADD_M: cd_next = cd_reg + m_s;
            OP_SUB_M: cd_next = dx;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= value;
            u_reg  <= modulus;
            v_reg  <= value;
            ca_reg <= CW'(1);
            cb_reg <= '0;
            cc_reg <= '0;
            cd_reg <= CW'(1);
        end
        else
        begin
            u_reg  <= u_next;
            v_reg  <= v_next;
            ca_reg <= ca_next;
            cb_reg <= cb_next;
            cc_reg <= cc_next;
            cd_reg <= cd_next;
        end
    end

    assign flags.m_zero    = modulus == '0;
    assign flags.m_one     = modulus == W'(1);
    assign flags.a_zero    = a_reg == '0;
    assign flags.both_even = !a_reg[0] && !modulus[0];
    assign flags.u_odd     = u_reg[0];
    assign flags.v_odd     = v_reg[0];
    assign flags.u_nonzero = |u_reg;
    assign flags.v_not_one = v_reg != W'(1);
    assign flags.d_nonneg  = !cd_reg[CW-1];
    assign flags.d_lt_m    = cd_reg < m_s;

    assign d_low = cd_reg[W-1:0];

endmodule
